FILE: rtl/core/cvcm_pkg.sv
`default_nettype none
package cvcm_pkg;

  localparam int CASTERS_DEF = 4;
  localparam int CASTER_X_OFFSET_DEF = 1024;
  localparam int CASTER_Y_OFFSET_DEF = 1024;
  localparam int SINE_TABLE_BITS_DEF = 10;

  localparam int VEL_W = 20;
  localparam int ANG_W = 16;
  localparam int RATE_W = 24;
  localparam int CFG_W = 19;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_TRANS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ROT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TRANS_UP = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TRANS_DOWN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ROT_UP = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ROT_DOWN = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_INV_OFFSET = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_INV_RADIUS = 3'd7;

  typedef struct packed {
    logic signed [VEL_W-1:0] vx_cmd;
    logic signed [VEL_W-1:0] vy_cmd;
    logic signed [VEL_W-1:0] wz_cmd;
    logic [ANG_W-1:0] steer_angle_a;
    logic [ANG_W-1:0] steer_angle_b;
    logic [ANG_W-1:0] steer_angle_c;
    logic [ANG_W-1:0] steer_angle_d;
  } cmd_t;

  typedef struct packed {
    logic [1:0] caster_index;
    logic signed [RATE_W-1:0] steer_rate;
    logic signed [RATE_W-1:0] roll_rate;
    logic last_caster;
  } rate_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_LIMIT, ST_TRIG, ST_COEF, ST_SUM, ST_OUT
  } state_t;

  function automatic logic [14:0] quarter_sine(input logic [16:0] x);
    logic [33:0] x2;
    logic [63:0] p;
    logic [63:0] y;
    begin
      x2 = ({17'd0, x} * {17'd0, x}) >> 16;
      p = 64'd5026995;
      p = 64'd85569306 - ((p * {30'd0, x2}) >> 16);
      p = 64'd693598668 - ((p * {30'd0, x2}) >> 16);
      p = 64'd1686629713 - ((p * {30'd0, x2}) >> 16);
      y = (((p * {47'd0, x}) >> 16) + 64'd32768) >> 16;
      if (y > 64'd16384) y = 64'd16384;
      quarter_sine = y[14:0];
    end
  endfunction

  function automatic logic signed [15:0] table_sine(input logic [15:0] phase);
    logic [16:0] x;
    logic [14:0] v;
    begin
      x = phase[14] ? {1'b0, 16'd0} + ((17'd16384 - {3'd0, phase[13:0]}) << 2)
                    : {1'b0, phase[13:0], 2'b00};
      v = quarter_sine(x);
      table_sine = phase[15] ? -$signed({1'b0, v}) : $signed({1'b0, v});
    end
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/cvcm_stream_if.sv
`default_nettype none
interface cvcm_stream_if #(parameter type payload_t = logic);
  logic valid;
  logic ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/caster_velocity_command_mapper.sv
// Caster velocity command mapper.
// The cmd channel takes one beat per control tick: a body velocity command
// (vx, vy, yaw rate) and the four caster steer angles. The rate channel
// returns CASTERS beats per tick, one per caster in order, with last_caster
// set on the final one. Each command axis is clamped, then the kept desired
// velocity moves toward it by at most the configured step.
// Work is done by one shared 32x32 signed multiplier under a sequencer.
// Per caster: the table read (ST_TRIG), the multiplies for the two factors
// (ST_COEF) and for the sums (ST_SUM), then the beat is presented (ST_OUT).
// cmd ready is low until the tick ends, receiver stalls included. The first
// rate beat comes after ST_LIMIT, ST_TRIG, ST_COEF and ST_SUM in turn.
// When the receiver stalls, the sequencer holds with the beat on the port.
// Reset clears the desired velocity to zero and loads the register defaults:
// limits and steps zero, both reciprocals 1.0.
// Configuration writes go through cfg_we, cfg_index and cfg_data; the user
// must make them only while the block is idle, which the block does not enforce.
`default_nettype none
module caster_velocity_command_mapper
  import cvcm_pkg::*;
#(
  parameter int CASTERS = CASTERS_DEF,
  parameter int CASTER_X_OFFSET = CASTER_X_OFFSET_DEF,
  parameter int CASTER_Y_OFFSET = CASTER_Y_OFFSET_DEF,
  parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
) (
  input wire logic clk,
  input wire logic rst,
  input wire logic cfg_we,
  input wire logic [CFG_IDX_W-1:0] cfg_index,
  input wire logic [CFG_W-1:0] cfg_data,
  cvcm_stream_if.sink cmd,
  cvcm_stream_if.source rate
);
  logic [CFG_W-1:0] max_trans_speed, max_rot_speed;
  logic [CFG_W-1:0] trans_step_up, trans_step_down, rot_step_up, rot_step_down;
  logic [15:0] inv_caster_offset, inv_wheel_radius;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_trans_speed <= '0;
      max_rot_speed <= '0;
      trans_step_up <= '0;
      trans_step_down <= '0;
      rot_step_up <= '0;
      rot_step_down <= '0;
      inv_caster_offset <= 16'd256;
      inv_wheel_radius <= 16'd256;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MAX_TRANS: max_trans_speed <= cfg_data;
        REG_MAX_ROT: max_rot_speed <= cfg_data;
        REG_TRANS_UP: trans_step_up <= cfg_data;
        REG_TRANS_DOWN: trans_step_down <= cfg_data;
        REG_ROT_UP: rot_step_up <= cfg_data;
        REG_ROT_DOWN: rot_step_down <= cfg_data;
        REG_INV_OFFSET: inv_caster_offset <= cfg_data[15:0];
        REG_INV_RADIUS: inv_wheel_radius <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  state_t state, state_next;
  cmd_t item;
  logic signed [VEL_W-1:0] dv [3];
  logic [1:0] ci;
  logic [3:0] step;
  logic signed [15:0] sin_q, cos_q;
  logic signed [15:0] s, c;
  logic signed [63:0] acc_s, acc_r;
  logic signed [31:0] ma, mb;
  logic signed [63:0] prod;
  logic signed [31:0] kfac;
  logic signed [31:0] scale_a, scale_b;
  logic signed [31:0] ks, kr;
  logic [ANG_W-1:0] angle;

  assign prod = ma * mb;

  always_comb begin
    case (ci)
      2'd0: angle = item.steer_angle_a;
      2'd1: angle = item.steer_angle_b;
      2'd2: angle = item.steer_angle_c;
      default: angle = item.steer_angle_d;
    endcase
  end

  cvcm_sine_rom #(.SINE_TABLE_BITS(SINE_TABLE_BITS)) u_rom (
    .clk(clk), .angle(angle), .sin_q(sin_q), .cos_q(cos_q)
  );

  // The table is read in the cycle after the caster index settles and its
  // output holds for the rest of the caster.
  assign s = sin_q;
  assign c = cos_q;

  function automatic logic signed [VEL_W-1:0] clamp_mag(
    input logic signed [VEL_W-1:0] v, input logic [CFG_W-1:0] lim);
    logic signed [VEL_W:0] l;
    begin
      l = $signed({2'b00, lim});
      if (VEL_W'(0) == 0 && ($signed({v[VEL_W-1], v}) < l)
          && ($signed({v[VEL_W-1], v}) > -l)) clamp_mag = v;
      else if (v[VEL_W-1]) clamp_mag = VEL_W'(-l);
      else clamp_mag = VEL_W'(l);
    end
  endfunction

  function automatic logic signed [VEL_W-1:0] slew(
    input logic signed [VEL_W-1:0] cmdv, input logic signed [VEL_W-1:0] cur,
    input logic [CFG_W-1:0] up, input logic [CFG_W-1:0] down);
    logic signed [VEL_W+1:0] d, r;
    begin
      d = $signed({{2{cmdv[VEL_W-1]}}, cmdv}) - $signed({{2{cur[VEL_W-1]}}, cur});
      if (!d[VEL_W+1]) r = (d < $signed({3'b000, up})) ? d : $signed({3'b000, up});
      else r = (d > -$signed({3'b000, down})) ? d : -$signed({3'b000, down});
      slew = VEL_W'($signed({{2{cur[VEL_W-1]}}, cur}) + r);
    end
  endfunction

  function automatic logic signed [RATE_W-1:0] round_sat(input logic signed [63:0] a);
    logic signed [63:0] r;
    begin
      r = (a + 64'sd2097152) >>> 22;
      if (r > 64'sd8388607) round_sat = 24'sh7FFFFF;
      else if (r < -64'sd8388608) round_sat = 24'sh800000;
      else round_sat = r[RATE_W-1:0];
    end
  endfunction

  logic signed [15:0] hx, hy;
  assign hx = (ci < 2'd2) ? 16'(CASTER_X_OFFSET) : -16'(CASTER_X_OFFSET);
  assign hy = (ci == 2'd1 || ci == 2'd2) ? 16'(CASTER_Y_OFFSET)
                                         : -16'(CASTER_Y_OFFSET);

  logic signed [31:0] vx32, vy32, wz32, ib32, ir32;
  assign vx32 = 32'(dv[0]);
  assign vy32 = 32'(dv[1]);
  assign wz32 = 32'(dv[2]);
  assign ib32 = $signed({16'd0, inv_caster_offset});
  assign ir32 = $signed({16'd0, inv_wheel_radius});

  // Multiplier operand schedule per caster.
  always_comb begin
    ma = '0;
    mb = '0;
    case (step)
      4'd0: begin ma = 32'(hx); mb = 32'(c); end
      4'd1: begin ma = 32'(hy); mb = 32'(s); end
      4'd2: begin ma = kfac; mb = ib32; end
      4'd3: begin ma = 32'(hx); mb = 32'(s); end
      4'd4: begin ma = 32'(hy); mb = 32'(c); end
      4'd5: begin ma = kfac; mb = ir32; end
      4'd6: begin ma = 32'(s); mb = ib32; end
      4'd7: begin ma = 32'(c); mb = ib32; end
      4'd8: begin ma = scale_a; mb = vx32; end
      4'd9: begin ma = scale_b; mb = vy32; end
      4'd10: begin ma = ks; mb = wz32; end
      4'd11: begin ma = 32'(c); mb = ir32; end
      4'd12: begin ma = 32'(s); mb = ir32; end
      4'd13: begin ma = scale_a; mb = vx32; end
      4'd14: begin ma = scale_b; mb = vy32; end
      default: begin ma = kr; mb = wz32; end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (cmd.valid) state_next = ST_LIMIT;
      ST_LIMIT: state_next = ST_TRIG;
      ST_TRIG: state_next = ST_COEF;
      ST_COEF: if (step == 4'd5) state_next = ST_SUM;
      ST_SUM: if (step == 4'd15) state_next = ST_OUT;
      ST_OUT: if (rate.ready) begin
        state_next = (32'(ci) == CASTERS - 1) ? ST_IDLE : ST_TRIG;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.ready = (state == ST_IDLE);
    rate.valid = (state == ST_OUT);
    rate.data.caster_index = ci;
    rate.data.steer_rate = round_sat(acc_s);
    rate.data.roll_rate = round_sat(acc_r);
    rate.data.last_caster = (32'(ci) == CASTERS - 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      dv[0] <= '0;
      dv[1] <= '0;
      dv[2] <= '0;
      ci <= '0;
      step <= '0;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: if (cmd.valid) item <= cmd.data;
        ST_LIMIT: begin
          dv[0] <= slew(clamp_mag(item.vx_cmd, max_trans_speed), dv[0],
                        trans_step_up, trans_step_down);
          dv[1] <= slew(clamp_mag(item.vy_cmd, max_trans_speed), dv[1],
                        trans_step_up, trans_step_down);
          dv[2] <= slew(clamp_mag(item.wz_cmd, max_rot_speed), dv[2],
                        rot_step_up, rot_step_down);
          ci <= '0;
          step <= '0;
        end
        ST_TRIG: begin
          step <= '0;
        end
        ST_COEF: begin
          step <= step + 4'd1;
          case (step)
            4'd0: kfac <= $signed(prod[31:0]);
            4'd1: kfac <= kfac + $signed(prod[31:0]);
            4'd2: ks <= 32'((prod + 64'sd131072) >>> 18);
            4'd3: kfac <= $signed(prod[31:0]);
            4'd4: kfac <= kfac - $signed(prod[31:0]);
            default: kr <= 32'((prod + 64'sd131072) >>> 18);
          endcase
        end
        ST_SUM: begin
          step <= step + 4'd1;
          case (step)
            4'd6: scale_a <= $signed(prod[31:0]);
            4'd7: scale_b <= $signed(prod[31:0]);
            4'd8: acc_s <= prod;
            4'd9: acc_s <= acc_s - prod;
            4'd10: acc_s <= acc_s - (prod <<< 6) - (64'(wz32) <<< 22);
            4'd11: scale_a <= $signed(prod[31:0]);
            4'd12: scale_b <= $signed(prod[31:0]);
            4'd13: acc_r <= prod;
            4'd14: acc_r <= acc_r + prod;
            default: acc_r <= acc_r + (prod <<< 6);
          endcase
        end
        ST_OUT: if (rate.ready) ci <= ci + 2'd1;
        default: ;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    rate.valid |-> !cmd.ready) else $error("cmd ready while a beat is pending");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rate.valid && !rate.ready |=> rate.valid && $stable(ci))
    else $error("rate beat dropped under stall");
  a_start: assert property (@(posedge clk) disable iff (rst)
    cmd.valid && cmd.ready |=> state == ST_LIMIT) else $error("tick not started");
`endif
endmodule
`default_nettype wire

FILE: rtl/core/cvcm_sine_rom.sv
`default_nettype none
module cvcm_sine_rom
  import cvcm_pkg::*;
#(
  parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
) (
  input wire logic clk,
  input wire logic [ANG_W-1:0] angle,
  output logic signed [15:0] sin_q,
  output logic signed [15:0] cos_q
);
  localparam int ENTRIES = 1 << SINE_TABLE_BITS;
  localparam int STEP = ANG_W - SINE_TABLE_BITS;

  logic signed [15:0] rom [ENTRIES];
  logic [SINE_TABLE_BITS-1:0] idx;
  logic [SINE_TABLE_BITS-1:0] cidx;

  always_comb begin
    for (int k = 0; k < ENTRIES; k++) begin
      rom[k] = table_sine(16'(k << STEP));
    end
  end

  assign idx = angle[ANG_W-1 -: SINE_TABLE_BITS];
  assign cidx = idx + SINE_TABLE_BITS'(ENTRIES / 4);

  always_ff @(posedge clk) begin
    sin_q <= rom[idx];
    cos_q <= rom[cidx];
  end
endmodule
`default_nettype wire
